### hw/rtl/fir_aa_pkg.sv
// Shared types and constants for the 33-tap anti-aliasing FIR filter.
`timescale 1ns / 1ps

package fir_aa_pkg;

	localparam int TAP_COUNT = 33;
	localparam int PTR_W     = 6;
	localparam int TAP_W     = 18;
	localparam int TAP_FRAC  = 17;
	localparam int ACC_W     = 40;
	localparam int RND_W     = ACC_W + 1 - TAP_FRAC;

	localparam logic signed [TAP_W-1:0] TAP_TABLE [TAP_COUNT] = '{
		-18'sd22,    -18'sd133,   -18'sd418,   -18'sd848,   -18'sd1125,
		-18'sd746,    18'sd548,    18'sd2175,   18'sd2662,   18'sd646,
		-18'sd3485,  -18'sd6753,  -18'sd4890,   18'sd4529,   18'sd19363,
		 18'sd33144,  18'sd38764,  18'sd33144,  18'sd19363,  18'sd4529,
		-18'sd4890,  -18'sd6753,  -18'sd3485,   18'sd646,    18'sd2662,
		 18'sd2175,   18'sd548,   -18'sd746,   -18'sd1125,  -18'sd848,
		-18'sd418,   -18'sd133,   -18'sd22
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} fir_state_t;

endpackage

### hw/rtl/fir_antialias_filter_33tap.sv
// Top level of the 33-tap anti-aliasing FIR filter with one shared multiply-accumulate unit.
//
// Channel   Signals                          Direction
// in        in_valid, in_stall, sample,      into the block
//           emit_output
// out       out_valid, out_stall, filtered   out of the block
//
// A transfer without the emit flag only stores the sample.
// A transfer with the emit flag holds in_stall high until the output register is loaded:
// 33 reads of the history memory, one per cycle, through a read register and a product
// register into the single accumulator, a drain of that pipeline, then rounding and
// saturation of the sum and the load of the output register.
// Reset clears the control state and marks every history entry as zero.
// A result waiting in the output register holds off new input transfers only once the next
// result is ready; the block then stays busy for as long as out_stall is held.
`timescale 1ns / 1ps

module fir_antialias_filter_33tap
	import fir_aa_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          emit_output,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered
);

	localparam int PROD_W = SAMPLE_BITS + TAP_W;
	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAP_COUNT - 1);

	fir_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] hist_mem [TAP_COUNT];
	logic [TAP_COUNT-1:0]          hist_vld_q;
	logic [PTR_W-1:0]              wr_pos_q;
	logic [PTR_W-1:0]              rd_ptr_q;
	logic [PTR_W-1:0]              rd_cnt_q;
	logic [PTR_W-1:0]              wpos;
	logic [PTR_W-1:0]              wpos_next;

	logic                          vld_s1;
	logic                          hvld_s1;
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	logic [PTR_W-1:0]              tap_idx_s1;
	logic                          vld_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic                          in_xfer;
	logic                          issue;
	logic                          start;
	logic                          load_out;
	logic [ACC_W:0]                rnd_sum;
	logic signed [RND_W-1:0]       rnd;
	logic signed [RND_W-1:0]       sat;
	logic signed [SAMPLE_BITS-1:0] mul_a;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	assign wpos      = (wr_pos_q >= PTR_W'(TAP_COUNT)) ? '0 : wr_pos_q;
	assign wpos_next = (wpos == PTR_LAST) ? '0 : wpos + PTR_W'(1);

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		start    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && emit_output) begin
					start   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (rd_cnt_q == PTR_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_pos_q    <= '0;
			hist_vld_q  <= '0;
			rd_ptr_q    <= '0;
			rd_cnt_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			if (in_xfer) begin
				wr_pos_q         <= wpos_next;
				hist_vld_q[wpos] <= 1'b1;
			end
			if (start) begin
				rd_ptr_q <= wpos;
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_ptr_q <= (rd_ptr_q == '0) ? PTR_LAST : rd_ptr_q - PTR_W'(1);
				rd_cnt_q <= rd_cnt_q + PTR_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			hist_mem[wpos] <= sample;
		end
		rdata_s1   <= hist_mem[rd_ptr_q];
		hvld_s1    <= hist_vld_q[rd_ptr_q];
		tap_idx_s1 <= rd_cnt_q;
	end

	assign mul_a = hvld_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * TAP_TABLE[tap_idx_s1];
		if (start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (load_out) begin
			filtered_q <= sat[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		rnd_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W + 1)'(1 << (TAP_FRAC - 1));
		rnd     = rnd_sum[ACC_W:TAP_FRAC];
		if (rnd > SAT_HI) begin
			sat = SAT_HI;
		end else if (rnd < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = rnd;
		end
	end

	a_accumulate_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("Product reached the accumulator outside the busy phases.");

	a_emit_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && emit_output) |=> (state_q == ST_RUN && in_stall))
		else $error("Emit transfer did not start the accumulation.");

	a_wr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pos_q < PTR_W'(TAP_COUNT))
		else $error("Write position left the history range.");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && $past(state_q) == ST_RUN) |-> ($past(rd_cnt_q) == PTR_LAST))
		else $error("Accumulation left the run phase before all taps were read.");

endmodule
